>>> src/salru_pkg.sv
// Shared constants, types and helpers of the set-associative LRU tag lookup.
package salru_pkg;

  localparam int unsigned LkpSets       = 64;
  localparam int unsigned LkpWays       = 4;
  localparam int unsigned LkpBlockBytes = 64;
  localparam int unsigned LkpAddrBits   = 32;

  localparam int unsigned OffW  = $clog2(LkpBlockBytes);
  localparam int unsigned SetW  = (LkpSets > 1) ? $clog2(LkpSets) : 1;
  localparam int unsigned TagW  = LkpAddrBits - OffW - $clog2(LkpSets);
  localparam int unsigned AgeW  = 4;
  localparam int unsigned WayOW = 2;

  localparam logic [AgeW-1:0] AgeMax = AgeW'(15);

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  // Outcome of one item, handed from the update logic to the top level.
  typedef struct packed {
    logic             hit;
    logic             write;
    logic [WayOW-1:0] way;
  } res_t;

  function automatic logic [AgeW-1:0] age_up(input logic [AgeW-1:0] a);
    logic [AgeW-1:0] r;
    r = (a >= AgeMax) ? AgeMax : a + AgeW'(1);
    return r;
  endfunction

endpackage

>>> src/salru_update.sv
// Hit detection, victim choice and age update for the ways of one set.
module salru_update import salru_pkg::*; #(
  parameter int unsigned WAYS = LkpWays,
  localparam int unsigned WIW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  func_e                      func_i,
  input  logic [TagW-1:0]            tag_i,
  input  logic [WAYS-1:0]            valid_i,
  input  logic [WAYS-1:0][TagW-1:0]  tags_i,
  input  logic [WAYS-1:0][AgeW-1:0]  ages_i,
  output res_t                       res_o,
  output logic [WIW-1:0]             sel_o,
  output logic [WAYS-1:0][TagW-1:0]  tags_o,
  output logic [WAYS-1:0][AgeW-1:0]  ages_o
);

  always_comb begin
    logic                       hit_found;
    logic                       inv_found;
    logic [WIW-1:0]             hit_idx;
    logic [WIW-1:0]             vic_idx;
    logic [AgeW-1:0]            hit_age;
    logic [AgeW-1:0]            best;
    logic [WAYS-1:0][AgeW-1:0]  ages;
    logic [WIW+1:0]             way_wide;

    // Ages of ways that were never filled are never looked at; read them as zero.
    for (int w = 0; w < WAYS; w++) begin
      ages[w] = valid_i[w] ? ages_i[w] : '0;
    end

    hit_found = 1'b0;
    hit_idx   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_found && valid_i[w] && (tags_i[w] == tag_i)) begin
        hit_found = 1'b1;
        hit_idx   = WIW'(w);
      end
    end
    hit_age = ages[hit_idx];

    // First empty way wins; otherwise the oldest, with ties going to the later way.
    inv_found = 1'b0;
    vic_idx   = '0;
    best      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!inv_found) begin
        if (!valid_i[w]) begin
          inv_found = 1'b1;
          vic_idx   = WIW'(w);
        end else if (ages[w] >= best) begin
          best    = ages[w];
          vic_idx = WIW'(w);
        end
      end
    end

    tags_o = tags_i;
    ages_o = ages;
    if (func_i == FUNC_INSERT) begin
      for (int w = 0; w < WAYS; w++) begin
        ages_o[w] = age_up(ages[w]);
      end
      ages_o[vic_idx] = '0;
      tags_o[vic_idx] = tag_i;
      sel_o           = vic_idx;
      res_o.hit       = 1'b0;
      res_o.write     = 1'b1;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (ages[w] < hit_age) begin
          ages_o[w] = age_up(ages[w]);
        end
      end
      ages_o[hit_idx] = '0;
      sel_o           = hit_idx;
      res_o.hit       = hit_found;
      res_o.write     = hit_found;
    end

    way_wide  = {2'b00, sel_o};
    res_o.way = (res_o.write) ? way_wide[WayOW-1:0] : '0;
  end

endmodule

>>> src/set_assoc_lru_tag_lookup_top.sv
// Top level of the set-associative cache tag and LRU age store.
//
//   Channel  Direction  Handshake               Fields
//   in       input      in_valid_i / in_ready_o  func_i, address_i
//   out      output     out_valid_o / out_ready_i hit_o, way_o
//
// On acceptance of an item the set's tag and age row is read into a register; the row is
// then compared and updated and the result registered, one item per cycle unless stalled.
// A write of a row is forwarded to an item that read the same set in that same cycle.
// Reset clears all valid bits at once; tags and ages need no clearing pass.
// A stalled result holds the update stage, which holds the input side in turn.
module set_assoc_lru_tag_lookup_top import salru_pkg::*; #(
  parameter int unsigned WAYS = LkpWays,
  localparam int unsigned WIW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [LkpAddrBits-1:0] address_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [WayOW-1:0]       way_o
);

  logic [TagW-1:0] in_tag;
  logic [SetW-1:0] in_set;
  logic            in_fire;
  logic            s1_fire;

  logic            s1_valid_q;
  func_e           s1_func_q;
  logic [TagW-1:0] s1_tag_q;
  logic [SetW-1:0] s1_set_q;

  logic [WAYS-1:0][TagW-1:0] rd_tags_q;
  logic [WAYS-1:0][AgeW-1:0] rd_ages_q;
  logic [WAYS-1:0][TagW-1:0] fw_tags_q;
  logic [WAYS-1:0][AgeW-1:0] fw_ages_q;
  logic [SetW-1:0]           fw_set_q;
  logic                      fw_valid_q;

  logic [WAYS-1:0][TagW-1:0] cur_tags;
  logic [WAYS-1:0][AgeW-1:0] cur_ages;
  logic [WAYS-1:0][TagW-1:0] new_tags;
  logic [WAYS-1:0][AgeW-1:0] new_ages;
  logic [WIW-1:0]            s1_sel;
  res_t                      s1_res;

  logic [WAYS-1:0][TagW-1:0] tag_mem [LkpSets];
  logic [WAYS-1:0][AgeW-1:0] age_mem [LkpSets];
  logic [WAYS-1:0]           vld_q   [LkpSets];

  logic                      out_valid_q;
  logic                      hit_q;
  logic [WayOW-1:0]          way_q;

  assign in_set = address_i[OffW +: SetW];
  assign in_tag = address_i[OffW + $clog2(LkpSets) +: TagW];

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // The row read at the edge of the last write may be stale; take the written row instead.
  assign cur_tags = (fw_valid_q && (fw_set_q == s1_set_q)) ? fw_tags_q : rd_tags_q;
  assign cur_ages = (fw_valid_q && (fw_set_q == s1_set_q)) ? fw_ages_q : rd_ages_q;

  salru_update #(
    .WAYS(WAYS)
  ) u_update (
    .func_i (s1_func_q),
    .tag_i  (s1_tag_q),
    .valid_i(vld_q[s1_set_q]),
    .tags_i (cur_tags),
    .ages_i (cur_ages),
    .res_o  (s1_res),
    .sel_o  (s1_sel),
    .tags_o (new_tags),
    .ages_o (new_ages)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_tags_q <= tag_mem[in_set];
      rd_ages_q <= age_mem[in_set];
    end
    if (s1_fire && s1_res.write) begin
      tag_mem[s1_set_q] <= new_tags;
      age_mem[s1_set_q] <= new_ages;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= func_e'(func_i);
      s1_tag_q  <= in_tag;
      s1_set_q  <= in_set;
    end
    if (s1_fire && s1_res.write) begin
      fw_tags_q <= new_tags;
      fw_ages_q <= new_ages;
      fw_set_q  <= s1_set_q;
    end
    if (s1_fire) begin
      hit_q <= s1_res.hit;
      way_q <= s1_res.way;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fw_valid_q  <= 1'b0;
      for (int s = 0; s < LkpSets; s++) begin
        vld_q[s] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire && s1_res.write) begin
        fw_valid_q <= 1'b1;
      end
      if (s1_fire && (s1_func_q == FUNC_INSERT)) begin
        vld_q[s1_set_q][s1_sel] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = way_q;

  a_insert_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_func_q == FUNC_INSERT)) |-> !s1_res.hit)
    else $error("insert reported a hit");

  a_hit_way_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_res.hit) |-> vld_q[s1_set_q][s1_sel])
    else $error("hit reported on an empty way");

  a_written_way_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_res.write) |=> vld_q[$past(s1_set_q)][$past(s1_sel)])
    else $error("written way is not valid after the update");

endmodule

>>> sim/set_assoc_lru_tag_lookup_top_test.sv
// Self-checking testbench for the set-associative LRU tag lookup top level.
`timescale 1ns / 100ps

module set_assoc_lru_tag_lookup_top_test;
  import salru_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [WayOW-1:0] way;
  } lookup_res_t;

  typedef struct packed {
    func_e                  op;
    logic [LkpAddrBits-1:0] addr;
    logic                   pinned;
    logic                   hit;
    logic [WayOW-1:0]       way;
  } probe_row_t;

  localparam int unsigned ProbeRows = 22;
  localparam int unsigned RandItems = 800;

  // Rows with pinned set carry a result that is plain from the row itself.
  localparam probe_row_t ProbeTbl [ProbeRows] = '{
    '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 2'd0},  // empty cache
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0},  // first free way of set 63
    '{FUNC_LOOKUP, 32'hFFFF_FFC0, 1'b1, 1'b1, 2'd0},
    '{FUNC_INSERT, 32'h0000_0FC0, 1'b1, 1'b0, 2'd1},
    '{FUNC_LOOKUP, 32'h0000_0FFF, 1'b1, 1'b1, 2'd1},
    '{FUNC_INSERT, 32'h0000_0000, 1'b1, 1'b0, 2'd0},  // fill all four ways of set 0
    '{FUNC_INSERT, 32'h0000_1000, 1'b1, 1'b0, 2'd1},
    '{FUNC_INSERT, 32'h0000_2000, 1'b1, 1'b0, 2'd2},
    '{FUNC_INSERT, 32'h0000_3000, 1'b1, 1'b0, 2'd3},
    '{FUNC_LOOKUP, 32'h0000_4000, 1'b1, 1'b0, 2'd0},  // miss on a full set
    '{FUNC_LOOKUP, 32'h0000_2010, 1'b0, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'h0000_1000, 1'b0, 1'b0, 2'd0},  // second copy of a line
    '{FUNC_LOOKUP, 32'h0000_103F, 1'b0, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'h0000_5000, 1'b0, 1'b0, 2'd0},
    '{FUNC_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 2'd0},
    '{FUNC_LOOKUP, 32'h0000_3000, 1'b0, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'h0000_0000, 1'b0, 1'b0, 2'd0},
    '{FUNC_LOOKUP, 32'h8000_0000, 1'b1, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'h8000_003F, 1'b0, 1'b0, 2'd0},
    '{FUNC_LOOKUP, 32'h7FFF_FFC0, 1'b1, 1'b0, 2'd0},
    '{FUNC_INSERT, 32'hFFFF_F000, 1'b0, 1'b0, 2'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  func_e                  func_i;
  logic [LkpAddrBits-1:0] address_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   hit_o;
  logic [WayOW-1:0]       way_o;

  // Pinned expectation that travels with the item on offer.
  logic             pin_en;
  logic             pin_hit;
  logic [WayOW-1:0] pin_way;

  logic            line_vld [LkpSets][LkpWays];
  logic [TagW-1:0] line_tg  [LkpSets][LkpWays];
  logic [AgeW-1:0] line_ag  [LkpSets][LkpWays];

  lookup_res_t pending_q [$];
  int unsigned error_count;
  int unsigned results_seen;
  bit          quiet;

  set_assoc_lru_tag_lookup_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .address_i   (address_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .way_o       (way_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [AgeW-1:0] older(input logic [AgeW-1:0] a);
    return (a >= AgeMax) ? AgeMax : a + AgeW'(1);
  endfunction

  // Applies one item to the tag and age store and returns its result.
  // With four ways the ages never climb past three, so saturation is out of reach here.
  function automatic lookup_res_t cache_access(input func_e op,
                                               input logic [LkpAddrBits-1:0] addr);
    logic [SetW-1:0] s;
    logic [TagW-1:0] t;
    int              w;
    int              hw;
    int              vw;
    logic [AgeW-1:0] ha;
    logic [AgeW-1:0] oldest;
    lookup_res_t     r;
    s = addr[OffW +: SetW];
    t = addr[OffW + SetW +: TagW];
    r = '0;
    if (op == FUNC_LOOKUP) begin
      hw = -1;
      for (w = int'(LkpWays) - 1; w >= 0; w--) begin
        if (line_vld[s][w] && line_tg[s][w] == t) hw = w;
      end
      if (hw >= 0) begin
        ha = line_ag[s][hw];
        for (w = 0; w < LkpWays; w++) begin
          if (line_ag[s][w] < ha) line_ag[s][w] = older(line_ag[s][w]);
        end
        line_ag[s][hw] = '0;
        r.hit = 1'b1;
        r.way = hw[WayOW-1:0];
      end
    end else begin
      vw = 0;
      oldest = '0;
      for (w = 0; w < LkpWays; w++) begin
        if (!line_vld[s][w]) begin
          vw = w;
          break;
        end
        if (line_ag[s][w] >= oldest) begin
          oldest = line_ag[s][w];
          vw = w;
        end
      end
      for (w = 0; w < LkpWays; w++) line_ag[s][w] = older(line_ag[s][w]);
      line_ag[s][vw] = '0;
      line_vld[s][vw] = 1'b1;
      line_tg[s][vw] = t;
      r.way = vw[WayOW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    lookup_res_t want;
    lookup_res_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          flag_error("result with no item outstanding");
        end else begin
          want = pending_q.pop_front();
          if (hit_o !== want.hit)
            flag_error($sformatf("hit got %b want %b", hit_o, want.hit));
          if (way_o !== want.way)
            flag_error($sformatf("way got %0d want %0d", way_o, want.way));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = cache_access(func_i, address_i);
        if (pin_en) begin
          want.hit = pin_hit;
          want.way = pin_way;
        end else begin
          want = pred;
        end
        pending_q.push_back(want);
      end
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // One long hold-off lets the pipeline fill and back up into the input.
      if (!held_once && results_seen >= 250) begin
        held_once = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer(input func_e op, input logic [LkpAddrBits-1:0] addr,
                       input logic pinned, input logic hit, input logic [WayOW-1:0] way);
    if (!quiet) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    address_i  <= addr;
    pin_en     <= pinned;
    pin_hit    <= hit;
    pin_way    <= way;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : item_source
    logic [SetW-1:0]        hot_set [4];
    logic [TagW-1:0]        hot_tag [8];
    logic [LkpAddrBits-1:0] addr;
    func_e                  op;
    int                     n;
    int                     s;
    int                     w;
    error_count  = 0;
    results_seen = 0;
    quiet        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_LOOKUP;
    address_i    = '0;
    pin_en       = 1'b0;
    pin_hit      = 1'b0;
    pin_way      = '0;
    for (s = 0; s < LkpSets; s++) begin
      for (w = 0; w < LkpWays; w++) begin
        line_vld[s][w] = 1'b0;
        line_tg[s][w]  = '0;
        line_ag[s][w]  = '0;
      end
    end
    foreach (hot_set[i]) hot_set[i] = SetW'($urandom());
    foreach (hot_tag[i]) hot_tag[i] = TagW'($urandom());

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (n = 0; n < ProbeRows; n++) begin
      offer(ProbeTbl[n].op, ProbeTbl[n].addr, ProbeTbl[n].pinned,
            ProbeTbl[n].hit, ProbeTbl[n].way);
    end

    // Most items land on a few sets with a few tags, so sets fill up, hit and evict.
    for (n = 0; n < RandItems; n++) begin
      quiet = (n >= 400 && n < 500);
      if ($urandom_range(99) < 75) begin
        addr = {hot_tag[$urandom_range(7)], hot_set[$urandom_range(3)],
                OffW'($urandom())};
      end else begin
        addr = $urandom();
      end
      op = ($urandom_range(99) < 35) ? FUNC_INSERT : FUNC_LOOKUP;
      offer(op, addr, 1'b0, 1'b0, '0);
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
